>>> hdl/lfjc_pkg.sv
// ----------------------------------------------------------------------------
// lfjc_pkg: shared definitions for the line follower junction counter
// Sensor width, register indexes, reset values and the signed speed type.
// ----------------------------------------------------------------------------
package lfjc_pkg;

  // Width of one line-sensor sample
  localparam int unsigned AdcBits = 10;

  // Configuration port geometry
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] CfgIrThreshold = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgBaseSpeed   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgTurnSpeed   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgDebounceMs  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgTargetCount = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgReverseMode = 3'd5;

  // Register reset values
  localparam logic [AdcBits-1:0] IrThresholdRst = AdcBits'(750);
  localparam logic [7:0]         BaseSpeedRst   = 8'd80;
  localparam logic [7:0]         TurnSpeedRst   = 8'd20;
  localparam logic [15:0]        DebounceMsRst  = 16'd300;
  localparam logic [7:0]         TargetCountRst = 8'd3;

  // Trim applied to one wheel while cruising
  localparam logic [7:0] SpeedTrim = 8'd5;

  // Signed wheel speed, -255 .. 255
  typedef logic signed [8:0] speed_t;

  // Magnitude to signed speed
  function automatic speed_t to_speed(input logic [7:0] mag, input logic neg);
    speed_t s;
    s = speed_t'({1'b0, mag});
    return neg ? -s : s;
  endfunction

  // Signed speed to forward duty
  function automatic logic [7:0] fwd_duty(input speed_t s);
    return s[8] ? 8'd0 : s[7:0];
  endfunction

  // Signed speed to reverse duty
  function automatic logic [7:0] rev_duty(input speed_t s);
    speed_t m;
    m = -s;
    return s[8] ? m[7:0] : 8'd0;
  endfunction

endpackage

>>> hdl/line_follow_junction_counter.sv
// ----------------------------------------------------------------------------
// line_follow_junction_counter: line follower with junction counting
// Thresholds five line samples, counts debounced junction edges and drives
// signed wheel speeds as forward and reverse PWM duties.
// ----------------------------------------------------------------------------
// One item per clock cycle sustained unless the output stalls. An item is
// captured in an input register, evaluated by compare and select logic against
// the run state, and lands in an output register when that register is empty
// or its result is being taken.
// While a finished result waits for its consumer, one more item can still be
// taken into an empty input register; after that the input stalls until the
// result is taken.
// Configuration writes take effect at once and are meant for idle periods.
module line_follow_junction_counter
  import lfjc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  // input item channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   start_req_i,
  input  logic [AdcBits-1:0]     far_left_i,
  input  logic [AdcBits-1:0]     near_left_i,
  input  logic [AdcBits-1:0]     centre_i,
  input  logic [AdcBits-1:0]     near_right_i,
  input  logic [AdcBits-1:0]     far_right_i,
  input  logic                   left_strip_i,
  input  logic                   right_strip_i,
  input  logic [31:0]            now_ms_i,
  // result item channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             left_fwd_pwm_o,
  output logic [7:0]             left_rev_pwm_o,
  output logic [7:0]             right_fwd_pwm_o,
  output logic [7:0]             right_rev_pwm_o,
  output logic [7:0]             junctions_seen_o,
  output logic                   run_done_o
);

  // Configuration registers
  logic [AdcBits-1:0] ir_threshold_q;
  logic [7:0]         base_speed_q;
  logic [7:0]         turn_speed_q;
  logic [15:0]        debounce_ms_q;
  logic [7:0]         target_count_q;
  logic               reverse_mode_q;

  // Run state
  logic        run_active_q, run_active_d;
  logic [7:0]  junction_cnt_q, junction_cnt_d;
  logic        prev_junction_q, prev_junction_d;
  logic [31:0] last_time_q, last_time_d;
  speed_t      held_left_q, held_left_d;
  speed_t      held_right_q, held_right_d;

  // Input register
  logic               in_vld_q;
  logic               start_q;
  logic [AdcBits-1:0] far_left_q, near_left_q, centre_q, near_right_q, far_right_q;
  logic               left_strip_q, right_strip_q;
  logic [31:0]        now_q;

  // Output register
  logic       out_vld_q;
  logic [7:0] lf_q, lr_q, rf_q, rr_q, cnt_out_q;
  logic       done_q;

  // Handshake
  logic out_load;
  logic in_load;

  assign out_load   = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_threshold_q <= IrThresholdRst;
      base_speed_q   <= BaseSpeedRst;
      turn_speed_q   <= TurnSpeedRst;
      debounce_ms_q  <= DebounceMsRst;
      target_count_q <= TargetCountRst;
      reverse_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIrThreshold: ir_threshold_q <= cfg_data_i[AdcBits-1:0];
        CfgBaseSpeed:   base_speed_q   <= cfg_data_i[7:0];
        CfgTurnSpeed:   turn_speed_q   <= cfg_data_i[7:0];
        CfgDebounceMs:  debounce_ms_q  <= cfg_data_i[15:0];
        CfgTargetCount: target_count_q <= cfg_data_i[7:0];
        CfgReverseMode: reverse_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Capture input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      start_q       <= start_req_i;
      far_left_q    <= far_left_i;
      near_left_q   <= near_left_i;
      centre_q      <= centre_i;
      near_right_q  <= near_right_i;
      far_right_q   <= far_right_i;
      left_strip_q  <= left_strip_i;
      right_strip_q <= right_strip_i;
      now_q         <= now_ms_i;
    end
  end

  // Evaluate one item
  logic        on_l2, on_l1, on_c, on_r1, on_r2;
  logic        run_eff, prev_base, junction, edge_hit;
  logic [7:0]  cnt_base, cnt_inc, goal, base_trim;
  logic [31:0] elapsed;
  logic        reached;
  speed_t      spd_l, spd_r;
  logic [7:0]  lf_d, lr_d, rf_d, rr_d;
  logic        done_d;

  always_comb begin
    on_l2 = far_left_q   < ir_threshold_q;
    on_l1 = near_left_q  < ir_threshold_q;
    on_c  = centre_q     < ir_threshold_q;
    on_r1 = near_right_q < ir_threshold_q;
    on_r2 = far_right_q  < ir_threshold_q;

    // start opens a run and clears the count
    run_eff   = run_active_q || start_q;
    cnt_base  = start_q ? 8'd0 : junction_cnt_q;
    prev_base = start_q ? 1'b0 : prev_junction_q;

    junction = reverse_mode_q ? (left_strip_q && right_strip_q)
                              : (left_strip_q || right_strip_q);
    elapsed  = now_q - last_time_q;
    edge_hit = junction && !prev_base && (elapsed > {16'd0, debounce_ms_q});
    cnt_inc  = (edge_hit && cnt_base != 8'hFF) ? cnt_base + 8'd1 : cnt_base;
    goal     = (target_count_q == 8'd0) ? 8'd1 : target_count_q;
    reached  = edge_hit && (cnt_inc >= goal);

    base_trim = (base_speed_q >= SpeedTrim) ? base_speed_q - SpeedTrim : 8'd0;

    // Priority steering over the thresholded sensors
    if (!reverse_mode_q) begin
      if (on_c) begin
        spd_l = to_speed(base_trim, 1'b0);    spd_r = to_speed(base_speed_q, 1'b0);
      end else if (on_r1) begin
        spd_l = to_speed(turn_speed_q, 1'b0); spd_r = to_speed(base_speed_q, 1'b0);
      end else if (on_r2) begin
        spd_l = '0;                           spd_r = to_speed(base_speed_q, 1'b0);
      end else if (on_l1) begin
        spd_l = to_speed(base_speed_q, 1'b0); spd_r = to_speed(turn_speed_q, 1'b0);
      end else if (on_l2) begin
        spd_l = to_speed(base_speed_q, 1'b0); spd_r = '0;
      end else begin
        spd_l = '0;                           spd_r = '0;
      end
    end else begin
      if (on_c) begin
        spd_l = to_speed(base_trim, 1'b1);    spd_r = to_speed(base_speed_q, 1'b1);
      end else if (on_l1) begin
        spd_l = to_speed(turn_speed_q, 1'b1); spd_r = to_speed(base_speed_q, 1'b1);
      end else if (on_l2) begin
        spd_l = '0;                           spd_r = to_speed(base_speed_q, 1'b1);
      end else if (on_r1) begin
        spd_l = to_speed(base_speed_q, 1'b1); spd_r = to_speed(turn_speed_q, 1'b1);
      end else if (on_r2) begin
        spd_l = to_speed(base_speed_q, 1'b1); spd_r = '0;
      end else begin
        spd_l = held_left_q;                  spd_r = held_right_q;
      end
    end

    // Defaults: hold state, motors stopped, run done
    run_active_d    = run_active_q;
    junction_cnt_d  = junction_cnt_q;
    prev_junction_d = prev_junction_q;
    last_time_d     = last_time_q;
    held_left_d     = held_left_q;
    held_right_d    = held_right_q;
    lf_d   = 8'd0;
    lr_d   = 8'd0;
    rf_d   = 8'd0;
    rr_d   = 8'd0;
    done_d = 1'b1;

    if (run_eff) begin
      junction_cnt_d  = cnt_inc;
      prev_junction_d = junction;
      if (edge_hit) begin
        last_time_d = now_q;
      end
      if (reached) begin
        run_active_d = 1'b0;
        held_left_d  = '0;
        held_right_d = '0;
      end else begin
        run_active_d = 1'b1;
        held_left_d  = spd_l;
        held_right_d = spd_r;
        lf_d   = fwd_duty(spd_l);
        lr_d   = rev_duty(spd_l);
        rf_d   = fwd_duty(spd_r);
        rr_d   = rev_duty(spd_r);
        done_d = 1'b0;
      end
    end
  end

  // Advance run state as each item is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q    <= 1'b0;
      junction_cnt_q  <= 8'd0;
      prev_junction_q <= 1'b0;
      last_time_q     <= 32'd0;
      held_left_q     <= '0;
      held_right_q    <= '0;
    end else if (out_load) begin
      run_active_q    <= run_active_d;
      junction_cnt_q  <= junction_cnt_d;
      prev_junction_q <= prev_junction_d;
      last_time_q     <= last_time_d;
      held_left_q     <= held_left_d;
      held_right_q    <= held_right_d;
    end
  end

  // Hold result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lf_q      <= lf_d;
      lr_q      <= lr_d;
      rf_q      <= rf_d;
      rr_q      <= rr_d;
      cnt_out_q <= junction_cnt_d;
      done_q    <= done_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign left_fwd_pwm_o   = lf_q;
  assign left_rev_pwm_o   = lr_q;
  assign right_fwd_pwm_o  = rf_q;
  assign right_rev_pwm_o  = rr_q;
  assign junctions_seen_o = cnt_out_q;
  assign run_done_o       = done_q;

endmodule

>>> bench/line_follow_junction_counter_tb.sv
// ----------------------------------------------------------------------------
// line_follow_junction_counter_tb: self-checking bench for the junction counter
// Drives sensor ticks through a valid/ready channel with random gaps and
// back-pressure, predicts every PWM result and compares it field by field.
// ----------------------------------------------------------------------------
module line_follow_junction_counter_tb;
  import lfjc_pkg::*;

  // One sensor tick as it crosses the input channel
  typedef struct packed {
    logic               start_req;
    logic [AdcBits-1:0] far_left;
    logic [AdcBits-1:0] near_left;
    logic [AdcBits-1:0] centre;
    logic [AdcBits-1:0] near_right;
    logic [AdcBits-1:0] far_right;
    logic               left_strip;
    logic               right_strip;
    logic [31:0]        now_ms;
  } tick_t;

  // One motor command as it leaves the block
  typedef struct packed {
    logic [7:0] left_fwd;
    logic [7:0] left_rev;
    logic [7:0] right_fwd;
    logic [7:0] right_rev;
    logic [7:0] junctions;
    logic       done;
  } drive_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx    = '0;
  logic [CfgDataBits-1:0] cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  tick_t                  drv_tick   = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  drive_t                 got_drive;

  // Ticks waiting to be sent and commands waiting to come back
  tick_t  tick_q[$];
  drive_t drive_q[$];
  int     queued_cnt = 0;
  int     taken_cnt  = 0;
  int     fail_cnt   = 0;
  int     gap_left   = 0;
  int     stall_left = 0;
  bit     pace_on    = 1'b1;

  // Predictor copy of the registers
  logic [AdcBits-1:0] cfg_thr    = IrThresholdRst;
  logic [7:0]         cfg_base   = BaseSpeedRst;
  logic [7:0]         cfg_turn   = TurnSpeedRst;
  logic [15:0]        cfg_deb    = DebounceMsRst;
  logic [7:0]         cfg_target = TargetCountRst;
  logic               cfg_rev    = 1'b0;

  // Predictor copy of the run state
  bit          run_active    = 1'b0;
  logic [7:0]  junc_cnt      = '0;
  bit          prev_junc     = 1'b0;
  logic [31:0] last_junc_ms  = '0;
  speed_t      held_left     = '0;
  speed_t      held_right    = '0;

  // Stimulus state
  logic [31:0] clock_ms   = '0;
  int          strip_left = 0;

  line_follow_junction_counter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .start_req_i      (drv_tick.start_req),
    .far_left_i       (drv_tick.far_left),
    .near_left_i      (drv_tick.near_left),
    .centre_i         (drv_tick.centre),
    .near_right_i     (drv_tick.near_right),
    .far_right_i      (drv_tick.far_right),
    .left_strip_i     (drv_tick.left_strip),
    .right_strip_i    (drv_tick.right_strip),
    .now_ms_i         (drv_tick.now_ms),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .left_fwd_pwm_o   (got_drive.left_fwd),
    .left_rev_pwm_o   (got_drive.left_rev),
    .right_fwd_pwm_o  (got_drive.right_fwd),
    .right_rev_pwm_o  (got_drive.right_rev),
    .junctions_seen_o (got_drive.junctions),
    .run_done_o       (got_drive.done)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random pause length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!pace_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Split a signed wheel speed into forward and reverse duty
  task automatic split_speed(input int s, output logic [7:0] fwd, output logic [7:0] rev);
    int m;
    m   = -s;
    fwd = (s >= 0) ? s[7:0] : 8'd0;
    rev = (s < 0) ? m[7:0] : 8'd0;
  endtask

  // Advance the run state by one tick and work out the motor command
  task automatic steer_tick(input tick_t tk, output drive_t dr);
    bit          on_fl, on_nl, on_c, on_nr, on_fr, junc, goal_hit;
    logic [31:0] since;
    logic [7:0]  goal;
    int          b, bt, t, l, r;
    on_fl    = tk.far_left < cfg_thr;
    on_nl    = tk.near_left < cfg_thr;
    on_c     = tk.centre < cfg_thr;
    on_nr    = tk.near_right < cfg_thr;
    on_fr    = tk.far_right < cfg_thr;
    b        = int'(cfg_base);
    bt       = (cfg_base >= SpeedTrim) ? int'(cfg_base) - 5 : 0;
    t        = int'(cfg_turn);
    goal     = (cfg_target == 8'd0) ? 8'd1 : cfg_target;
    l        = 0;
    r        = 0;
    dr.done  = 1'b1;
    goal_hit = 1'b0;
    // Start clears the count, then the same tick is processed
    if (tk.start_req) begin
      run_active = 1'b1;
      junc_cnt   = '0;
      prev_junc  = 1'b0;
    end
    if (run_active) begin
      junc  = cfg_rev ? (tk.left_strip && tk.right_strip) : (tk.left_strip || tk.right_strip);
      since = tk.now_ms - last_junc_ms;
      // Count a debounced rising junction edge
      if (junc && !prev_junc && since > {16'd0, cfg_deb}) begin
        if (junc_cnt != 8'd255) junc_cnt = junc_cnt + 8'd1;
        last_junc_ms = tk.now_ms;
        if (junc_cnt >= goal) begin
          run_active = 1'b0;
          held_left  = '0;
          held_right = '0;
          goal_hit   = 1'b1;
        end
      end
      prev_junc = junc;
      if (!goal_hit) begin
        dr.done = 1'b0;
        if (!cfg_rev) begin
          if (on_c)       begin l = bt; r = b; end
          else if (on_nr) begin l = t;  r = b; end
          else if (on_fr) begin l = 0;  r = b; end
          else if (on_nl) begin l = b;  r = t; end
          else if (on_fl) begin l = b;  r = 0; end
        end else begin
          if (on_c)       begin l = -bt; r = -b; end
          else if (on_nl) begin l = -t;  r = -b; end
          else if (on_fl) begin l = 0;   r = -b; end
          else if (on_nr) begin l = -b;  r = -t; end
          else if (on_fr) begin l = -b;  r = 0; end
          else begin
            // Lost the line going backward: repeat the last command
            l = held_left;
            r = held_right;
          end
        end
        held_left  = speed_t'(l);
        held_right = speed_t'(r);
      end
    end
    split_speed(l, dr.left_fwd, dr.left_rev);
    split_speed(r, dr.right_fwd, dr.right_rev);
    dr.junctions = junc_cnt;
  endtask

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_cnt < 50) $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_cnt++;
  endtask

  // Driver: hold each tick until taken, predict it on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    tick_t  nxt;
    drive_t dr;
    bit     busy;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        steer_tick(drv_tick, dr);
        drive_q.push_back(dr);
        taken_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          drv_tick <= nxt;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each result with the oldest command
  always @(posedge clk_i or negedge rst_ni) begin
    drive_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          want = drive_q.pop_front();
          if (got_drive.left_fwd !== want.left_fwd)
            report_mismatch("left_fwd_pwm", got_drive.left_fwd, want.left_fwd);
          if (got_drive.left_rev !== want.left_rev)
            report_mismatch("left_rev_pwm", got_drive.left_rev, want.left_rev);
          if (got_drive.right_fwd !== want.right_fwd)
            report_mismatch("right_fwd_pwm", got_drive.right_fwd, want.right_fwd);
          if (got_drive.right_rev !== want.right_rev)
            report_mismatch("right_rev_pwm", got_drive.right_rev, want.right_rev);
          if (got_drive.junctions !== want.junctions)
            report_mismatch("junctions_seen", got_drive.junctions, want.junctions);
          if (got_drive.done !== want.done)
            report_mismatch("run_done", got_drive.done, want.done);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Queue one tick for the driver
  task automatic add_tick(input bit st, input int fl, input int nl, input int c, input int nr,
                          input int fr, input bit ls, input bit rs, input logic [31:0] now);
    tick_t tk;
    tk.start_req   = st;
    tk.far_left    = fl[AdcBits-1:0];
    tk.near_left   = nl[AdcBits-1:0];
    tk.centre      = c[AdcBits-1:0];
    tk.near_right  = nr[AdcBits-1:0];
    tk.far_right   = fr[AdcBits-1:0];
    tk.left_strip  = ls;
    tk.right_strip = rs;
    tk.now_ms      = now;
    tick_q.push_back(tk);
    queued_cnt++;
  endtask

  // Write one register at the next edge
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CfgDataBits-1:0];
    case (idx)
      CfgIrThreshold: cfg_thr    = val[AdcBits-1:0];
      CfgBaseSpeed:   cfg_base   = val[7:0];
      CfgTurnSpeed:   cfg_turn   = val[7:0];
      CfgDebounceMs:  cfg_deb    = val[15:0];
      CfgTargetCount: cfg_target = val[7:0];
      CfgReverseMode: cfg_rev    = val[0];
      default: ;
    endcase
  endtask

  // Write the whole register set, then drop the enable
  task automatic write_all(input int thr, input int base, input int turn, input int deb,
                           input int target, input int rev);
    write_reg(CfgIrThreshold, thr);
    write_reg(CfgBaseSpeed, base);
    write_reg(CfgTurnSpeed, turn);
    write_reg(CfgDebounceMs, deb);
    write_reg(CfgTargetCount, target);
    write_reg(CfgReverseMode, rev);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every tick is taken and every command has come back
  task automatic wait_idle();
    while (taken_cnt != queued_cnt || drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random sample on or off the line, with the edges of the range favored
  function automatic int pick_sample(input bit on);
    int r;
    r = $urandom_range(0, 9);
    if (cfg_thr == '0) return $urandom_range(0, 1023);
    if (on) begin
      if (r == 0) return 0;
      if (r == 1) return int'(cfg_thr) - 1;
      return $urandom_range(0, int'(cfg_thr) - 1);
    end
    if (r == 0) return 1023;
    if (r == 1) return int'(cfg_thr);
    return $urandom_range(int'(cfg_thr), 1023);
  endfunction

  // Queue one run: a start, then ticks with line patterns and strip crossings
  task automatic queue_run(input int len);
    bit [4:0] on_mask;
    bit       ls, rs, st;
    int       r;
    for (int i = 0; i < len; i++) begin
      // Advance the timestamp, sometimes by a long jump
      r = $urandom_range(0, 99);
      if (r < 80)      clock_ms = clock_ms + $urandom_range(0, 60);
      else if (r < 95) clock_ms = clock_ms + $urandom_range(100, 800);
      else             clock_ms = clock_ms + $urandom();
      // Line pattern
      on_mask = '0;
      if ($urandom_range(0, 9) != 0)
        for (int k = 0; k < 5; k++) on_mask[k] = ($urandom_range(0, 2) == 0);
      // Strip crossing lasting a few ticks, otherwise rare noise
      ls = 1'b0;
      rs = 1'b0;
      if (strip_left == 0 && $urandom_range(0, 5) == 0) strip_left = $urandom_range(1, 4);
      if (strip_left > 0) begin
        strip_left--;
        if (cfg_rev && $urandom_range(0, 4) != 0) begin
          ls = 1'b1;
          rs = 1'b1;
        end else begin
          r  = $urandom_range(1, 3);
          ls = r[0];
          rs = r[1];
        end
      end else if ($urandom_range(0, 19) == 0) begin
        ls = 1'($urandom_range(0, 1));
        rs = 1'($urandom_range(0, 1));
      end
      st = (i == 0) || ($urandom_range(0, 49) == 0);
      add_tick(st, pick_sample(on_mask[0]), pick_sample(on_mask[1]), pick_sample(on_mask[2]),
               pick_sample(on_mask[3]), pick_sample(on_mask[4]), ls, rs, clock_ms);
    end
  endtask

  // One random phase under a fixed register setting
  task automatic run_phase(input int thr, input int base, input int turn, input int deb,
                           input int target, input int rev, input int n_ticks,
                           input bit pace, input bit near_wrap);
    int n, len;
    write_all(thr, base, turn, deb, target, rev);
    pace_on    = pace;
    strip_left = 0;
    clock_ms   = near_wrap ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
    n = 0;
    while (n < n_ticks) begin
      len = $urandom_range(8, 50);
      queue_run(len);
      // Idle ticks after the run, which keep the run going if it is not done
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        clock_ms = clock_ms + $urandom_range(0, 60);
        add_tick(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), clock_ms);
        n++;
      end
      n += len;
    end
    wait_idle();
  endtask

  // Main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings, going forward
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd50);           // idle before any run
    add_tick(1'b1, 1023, 1023, 1023, 1023, 1023, 1'b0, 1'b0, 32'd100); // start, line lost
    add_tick(1'b0, 1023, 1023, 0, 1023, 1023, 1'b0, 1'b0, 32'd110);
    add_tick(1'b0, 1023, 1023, 750, 749, 1023, 1'b0, 1'b0, 32'd120);   // threshold edge
    add_tick(1'b0, 1023, 1023, 1023, 1023, 0, 1'b0, 1'b0, 32'd130);
    add_tick(1'b0, 1023, 749, 750, 750, 750, 1'b0, 1'b0, 32'd140);
    add_tick(1'b0, 0, 1023, 1023, 1023, 1023, 1'b0, 1'b0, 32'd150);
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 32'd400);          // first junction
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 32'd450);          // held, no new edge
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 32'd460);
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 32'd500);          // inside debounce
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 32'd510);
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 32'd800);
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 32'd810);
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd1200);         // target reached
    add_tick(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 32'd1300);         // idle shows last count
    wait_idle();

    // Directed, going backward with a base speed below the trim
    write_all(750, 3, 255, 0, 2, 1);
    add_tick(1'b1, 1023, 1023, 1023, 1023, 1023, 1'b0, 1'b0, 32'd1400);
    add_tick(1'b0, 1023, 1023, 0, 1023, 1023, 1'b0, 1'b0, 32'd1410);
    add_tick(1'b0, 1023, 0, 1023, 0, 1023, 1'b0, 1'b0, 32'd1420);
    add_tick(1'b0, 0, 1023, 1023, 0, 0, 1'b0, 1'b0, 32'd1430);
    add_tick(1'b0, 1023, 1023, 1023, 0, 0, 1'b0, 1'b0, 32'd1440);
    add_tick(1'b0, 1023, 1023, 1023, 1023, 0, 1'b0, 1'b0, 32'd1450);
    add_tick(1'b0, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b0, 32'd1460); // hold, no AND
    add_tick(1'b0, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1, 32'd2000);
    add_tick(1'b0, 1023, 1023, 0, 1023, 1023, 1'b0, 1'b0, 32'd2000);
    add_tick(1'b0, 1023, 1023, 0, 1023, 1023, 1'b1, 1'b1, 32'd2001);
    wait_idle();

    // Random phases across the register ranges
    run_phase(750, 80, 20, 300, 3, 0, 200, 1'b1, 1'b0);
    run_phase(750, 80, 20, 300, 3, 1, 200, 1'b1, 1'b1);
    run_phase(0, 255, 0, 0, 0, 0, 60, 1'b0, 1'b0);
    run_phase(1023, 4, 255, 65535, 255, 1, 120, 1'b1, 1'b0);
    run_phase(512, 5, 255, 0, 1, 0, 100, 1'b1, 1'b1);
    run_phase(300, 255, 0, 1000, 8, 1, 150, 1'b0, 1'b0);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 1500), $urandom_range(0, 10), $urandom_range(0, 1),
                100, 1'b1, 1'($urandom_range(0, 1)));

    repeat (10) @(posedge clk_i);
    if (drive_q.size() != 0) report_mismatch("results never returned", 0, drive_q.size());
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> line_follow_junction_counter.f
hdl/lfjc_pkg.sv
hdl/line_follow_junction_counter.sv
bench/line_follow_junction_counter_tb.sv
